// ===== src/dwp_pkg.sv =====
// ----------------------------------------------------------------------------
// dwp_pkg: shared types and constants for the dual-wheel PID duty regulator
// Item formats, register indexes, reset values, sequencer states and the
// control bundle that drives the shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
`default_nettype none

package dwp_pkg;

  // Default parameter values
  localparam int FRAC_BITS_DEF   = 16;
  localparam int COUNT_WIDTH_DEF = 16;

  // Fixed field widths
  localparam int TGT_W      = 8;
  localparam int BASE_W     = 16;
  localparam int COEF_W     = 16;
  localparam int ERR_W      = 16;
  localparam int DUTY_W     = 16;
  localparam int OPA_W      = ERR_W + 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET     = 3'd0,
    CFG_LEFT_BASE  = 3'd1,
    CFG_RIGHT_BASE = 3'd2,
    CFG_PROP       = 3'd3,
    CFG_INTEG      = 3'd4,
    CFG_PREV       = 3'd5
  } cfg_idx_t;

  // Register reset values
  localparam logic [TGT_W-1:0]  TARGET_RST = 8'd8;
  localparam logic [BASE_W-1:0] BASE_RST   = 16'd5000;
  localparam logic [COEF_W-1:0] PROP_RST   = 16'd1966;
  localparam logic [COEF_W-1:0] INTEG_RST  = 16'd393;
  localparam logic [COEF_W-1:0] PREV_RST   = 16'd983;

  typedef struct packed {
    logic left_pulse;
    logic right_pulse;
    logic tick;
  } in_item_t;

  typedef struct packed {
    logic [DUTY_W-1:0] left_duty;
    logic [DUTY_W-1:0] right_duty;
    logic              updated;
  } out_item_t;

  // Shared unit control: issue a product, and restart the sum with it
  typedef struct packed {
    logic issue;
    logic clear;
  } mac_ctl_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_COUNT,
    S_ERR,
    S_MAC0,
    S_MAC1,
    S_MAC2,
    S_WAIT,
    S_CLAMP,
    S_DUTY0,
    S_DUTY1,
    S_DCAP0,
    S_DCAP1,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== src/dwp_if.sv =====
// ----------------------------------------------------------------------------
// dwp_if: valid/ready channels of the dual-wheel PID duty regulator
// One channel carries pulse/tick items in, the other carries duty items out.
// ----------------------------------------------------------------------------
`default_nettype none

interface dwp_pulse_if;
  import dwp_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface dwp_duty_if;
  import dwp_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/dwp_mac.sv =====
// ----------------------------------------------------------------------------
// dwp_mac: shared multiply-accumulate unit
// Signed product registered in stage one, accumulated in stage two. A result
// is in the accumulator once the last product has passed both stages.
// ----------------------------------------------------------------------------
`default_nettype none

module dwp_mac import dwp_pkg::*; #(
  parameter int OPB_W = 17
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire mac_ctl_t                      ctl,
  input  wire logic signed [OPA_W-1:0]       op_a,
  input  wire logic signed [OPB_W-1:0]       op_b,
  output logic signed [OPA_W+OPB_W+1:0]      acc
);

  localparam int PROD_W = OPA_W + OPB_W;
  localparam int ACC_W  = PROD_W + 2;

  logic signed [PROD_W-1:0] prod;
  mac_ctl_t                 prod_ctl;
  logic signed [ACC_W-1:0]  prod_ext;

  assign prod_ext = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_ctl <= '0;
    end else begin
      prod_ctl <= ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.issue) begin
      prod <= op_a * op_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (prod_ctl.issue) begin
      acc <= (prod_ctl.clear ? '0 : acc) + prod_ext;
    end
  end

endmodule

`default_nettype wire

// ===== src/dual_wheel_pid_duty.sv =====
// Sequencing: an item without a tick goes straight from counting to the duty products;
//   a tick first updates the gains (two wheels, three products each, on one multiplier).
// Flow: one item at a time; the sequencer holds ready low until the result is in the
//   output register, which waits while the output is stalled.
// Reset: synchronous, active high; registers return to defaults, counters,
//   errors and sums clear, both gains return to one.
// ----------------------------------------------------------------------------
// dual_wheel_pid_duty: two-wheel incremental PID duty regulator
// Counts encoder pulses per wheel and, on a tick, updates each wheel's gain
// with one shared multiply-accumulate unit; every item then scales the base duties.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_wheel_pid_duty import dwp_pkg::*; #(
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  dwp_pulse_if.sink                  pulse,
  dwp_duty_if.source                 duty,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int GAIN_W = FRAC_BITS + 1;
  localparam int OPB_W  = (FRAC_BITS + 2 > OPA_W) ? FRAC_BITS + 2 : OPA_W;
  localparam int ACC_W  = OPA_W + OPB_W + 2;
  localparam int DIFF_W = (COUNT_WIDTH + 1 > OPA_W) ? COUNT_WIDTH + 1 : OPA_W;

  localparam logic [GAIN_W-1:0]      GAIN_ONE  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
  localparam logic signed [DIFF_W-1:0] ERR_MIN =
    {{(DIFF_W-ERR_W+1){1'b1}}, {(ERR_W-1){1'b0}}};
  localparam logic signed [ERR_W-1:0] ERR_LO = {1'b1, {(ERR_W-1){1'b0}}};
  localparam logic signed [ERR_W-1:0] ERR_HI = {1'b0, {(ERR_W-1){1'b1}}};

  // Configuration registers
  logic [TGT_W-1:0]  target;
  logic [BASE_W-1:0] base_l;
  logic [BASE_W-1:0] base_r;
  logic [COEF_W-1:0] kp;
  logic [COEF_W-1:0] ki;
  logic [COEF_W-1:0] kd;

  // Wheel state, index 0 left, 1 right
  logic [COUNT_WIDTH-1:0]    count    [2];
  logic signed [ERR_W-1:0]   last_err [2];
  logic signed [ERR_W-1:0]   err_sum  [2];
  logic [GAIN_W-1:0]         gain     [2];

  // Sequencer and item registers
  state_t                  state;
  state_t                  state_next;
  logic                    wheel;
  logic                    lp_q;
  logic                    rp_q;
  logic                    tick_q;
  logic signed [ERR_W-1:0] err_q;
  logic [DUTY_W-1:0]       duty_l;
  logic [DUTY_W-1:0]       duty_r;
  logic                    out_valid;
  out_item_t               out_data;
  logic                    out_free;

  // Shared unit
  mac_ctl_t                 mac_ctl;
  logic signed [OPA_W-1:0]  op_a;
  logic signed [OPB_W-1:0]  op_b;
  logic signed [ACC_W-1:0]  acc;

  // Update arithmetic
  logic signed [DIFF_W-1:0] diff;
  logic signed [ERR_W-1:0]  err_sat;
  logic signed [ERR_W:0]    sum_ext;
  logic signed [ERR_W-1:0]  sum_sat;
  logic signed [ACC_W:0]    gain_sum;
  logic [GAIN_W-1:0]        gain_new;

  assign pulse.ready = (state == S_IDLE);
  assign duty.valid  = out_valid;
  assign duty.data   = out_data;
  assign out_free    = !out_valid || duty.ready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      target <= TARGET_RST;
      base_l <= BASE_RST;
      base_r <= BASE_RST;
      kp     <= PROP_RST;
      ki     <= INTEG_RST;
      kd     <= PREV_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TARGET:     target <= cfg_data[TGT_W-1:0];
        CFG_LEFT_BASE:  base_l <= cfg_data[BASE_W-1:0];
        CFG_RIGHT_BASE: base_r <= cfg_data[BASE_W-1:0];
        CFG_PROP:       kp     <= cfg_data[COEF_W-1:0];
        CFG_INTEG:      ki     <= cfg_data[COEF_W-1:0];
        CFG_PREV:       kd     <= cfg_data[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // Error of the selected wheel; the target is small, so only the low side saturates
  always_comb begin
    diff = $signed({{(DIFF_W-TGT_W){1'b0}}, target})
         - $signed({{(DIFF_W-COUNT_WIDTH){1'b0}}, count[wheel]});
    err_sat = (diff < ERR_MIN) ? ERR_LO : diff[ERR_W-1:0];
  end

  always_comb begin
    sum_ext = $signed({err_sum[wheel][ERR_W-1], err_sum[wheel]})
            + $signed({err_q[ERR_W-1], err_q});
    if (sum_ext[ERR_W] != sum_ext[ERR_W-1]) begin
      sum_sat = sum_ext[ERR_W] ? ERR_LO : ERR_HI;
    end else begin
      sum_sat = sum_ext[ERR_W-1:0];
    end
  end

  // Add the accumulated delta to the gain, clamp to [0, one]
  always_comb begin
    gain_sum = $signed({{(ACC_W+1-GAIN_W){1'b0}}, gain[wheel]})
             + $signed({acc[ACC_W-1], acc});
    if (gain_sum >= $signed({{(ACC_W+1-GAIN_W){1'b0}}, GAIN_ONE})) begin
      gain_new = GAIN_ONE;
    end else if (gain_sum[ACC_W] || gain_sum == '0) begin
      gain_new = '0;
    end else begin
      gain_new = gain_sum[GAIN_W-1:0];
    end
  end

  dwp_mac #(
    .OPB_W (OPB_W)
  ) u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctl  (mac_ctl),
    .op_a (op_a),
    .op_b (op_b),
    .acc  (acc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and shared unit operands
  always_comb begin
    state_next = state;
    mac_ctl    = '0;
    op_a       = '0;
    op_b       = '0;
    case (state)
      S_IDLE: begin
        if (pulse.valid) state_next = S_COUNT;
      end
      S_COUNT: begin
        state_next = tick_q ? S_ERR : S_DUTY0;
      end
      S_ERR: begin
        state_next = S_MAC0;
      end
      S_MAC0: begin
        mac_ctl    = '{issue: 1'b1, clear: 1'b1};
        op_a       = {err_q[ERR_W-1], err_q};
        op_b       = {{(OPB_W-COEF_W){1'b0}}, kp};
        state_next = S_MAC1;
      end
      S_MAC1: begin
        mac_ctl    = '{issue: 1'b1, clear: 1'b0};
        op_a       = {last_err[wheel][ERR_W-1], last_err[wheel]};
        op_b       = {{(OPB_W-COEF_W){1'b0}}, kd};
        state_next = S_MAC2;
      end
      S_MAC2: begin
        mac_ctl    = '{issue: 1'b1, clear: 1'b0};
        op_a       = {err_sum[wheel][ERR_W-1], err_sum[wheel]};
        op_b       = {{(OPB_W-COEF_W){1'b0}}, ki};
        state_next = S_WAIT;
      end
      S_WAIT: begin
        state_next = S_CLAMP;
      end
      S_CLAMP: begin
        state_next = wheel ? S_DUTY0 : S_ERR;
      end
      S_DUTY0: begin
        mac_ctl    = '{issue: 1'b1, clear: 1'b1};
        op_a       = {1'b0, base_l};
        op_b       = {{(OPB_W-GAIN_W){1'b0}}, gain[0]};
        state_next = S_DUTY1;
      end
      S_DUTY1: begin
        mac_ctl    = '{issue: 1'b1, clear: 1'b1};
        op_a       = {1'b0, base_r};
        op_b       = {{(OPB_W-GAIN_W){1'b0}}, gain[1]};
        state_next = S_DCAP0;
      end
      S_DCAP0: begin
        state_next = S_DCAP1;
      end
      S_DCAP1: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Wheel state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 2; i++) begin
        count[i]    <= '0;
        last_err[i] <= '0;
        err_sum[i]  <= '0;
        gain[i]     <= GAIN_ONE;
      end
    end else begin
      if (state == S_COUNT) begin
        if (lp_q && count[0] != COUNT_MAX) count[0] <= count[0] + 1'b1;
        if (rp_q && count[1] != COUNT_MAX) count[1] <= count[1] + 1'b1;
      end
      if (state == S_CLAMP) begin
        gain[wheel]     <= gain_new;
        count[wheel]    <= '0;
        last_err[wheel] <= err_q;
        err_sum[wheel]  <= sum_sat;
      end
    end
  end

  // Item, sequencing and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      wheel     <= 1'b0;
      tick_q    <= 1'b0;
      lp_q      <= 1'b0;
      rp_q      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pulse.valid && pulse.ready) begin
        lp_q   <= pulse.data.left_pulse;
        rp_q   <= pulse.data.right_pulse;
        tick_q <= pulse.data.tick;
        wheel  <= 1'b0;
      end
      if (state == S_CLAMP) wheel <= 1'b1;
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (duty.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_ERR) err_q <= err_sat;
    if (state == S_DCAP0) duty_l <= acc[FRAC_BITS +: DUTY_W];
    if (state == S_DCAP1) duty_r <= acc[FRAC_BITS +: DUTY_W];
    if (state == S_DONE && out_free) begin
      out_data <= '{left_duty: duty_l, right_duty: duty_r, updated: tick_q};
    end
  end

endmodule

`default_nettype wire

// ===== src/dwp_checker.sv =====
// ----------------------------------------------------------------------------
// dwp_checker: port-level checks for the dual-wheel PID duty regulator
// Watches the two channels and reset; attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module dwp_checker import dwp_pkg::*; (
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data
);

  // Busy while an item is being worked on
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after an accepted item");

  // Accepting an item does not raise the result valid straight away
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared one cycle after accept");

  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  a_out_valid_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_data_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result payload changed while stalled");

endmodule

bind dual_wheel_pid_duty dwp_checker u_dwp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (pulse.valid),
  .in_ready  (pulse.ready),
  .out_valid (duty.valid),
  .out_ready (duty.ready),
  .out_data  (duty.data)
);

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the dual-wheel PID duty regulator
// Drives pulse/tick items through the valid/ready input channel. Each accepted
// item runs through a cycle-free model of both wheels, which gives its duty
// item. The duty item is checked against it field by field. The run steps
// through several register settings and drives both error sums into their
// upper limit.
// ----------------------------------------------------------------------------
module testbench;
  import dwp_pkg::*;

  localparam int     GAIN_W      = FRAC_BITS_DEF + 1;
  localparam longint GAIN_ONE    = longint'(1) << FRAC_BITS_DEF;
  localparam longint PULSE_MAX   = (longint'(1) << (COUNT_WIDTH_DEF - 1)) - 1;
  localparam int     QUIET_LIMIT = 3000;
  localparam int     HOLD_CYCLES = 400;
  localparam int     TAIL_CYCLES = 40;
  localparam int     FILL_ITEMS  = 40;

  // Indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE7 = 3'd7;

  typedef struct {
    logic [COUNT_WIDTH_DEF-1:0] pulses;
    logic signed [ERR_W-1:0]    last_err;
    logic signed [ERR_W-1:0]    err_sum;
    logic [GAIN_W-1:0]          gain;
  } wheel_state_t;

  logic clk;
  logic rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  dwp_pulse_if pulse_ch ();
  dwp_duty_if  duty_ch ();

  dual_wheel_pid_duty dut (
    .clk       (clk),
    .rst       (rst),
    .pulse     (pulse_ch),
    .duty      (duty_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Register copy and wheel state of the model
  logic [TGT_W-1:0]  cfg_target;
  logic [BASE_W-1:0] cfg_left_base;
  logic [BASE_W-1:0] cfg_right_base;
  logic [COEF_W-1:0] cfg_prop;
  logic [COEF_W-1:0] cfg_integ;
  logic [COEF_W-1:0] cfg_prev;
  wheel_state_t      left_w;
  wheel_state_t      right_w;

  in_item_t  pending_items[$];
  out_item_t duty_expect[$];

  int src_idle_pct;
  int snk_idle_pct;
  int src_gap;
  int snk_gap;
  int hold_requests;
  int hold_served;
  int hold_left;
  int quiet_cycles;
  int errors;
  int items_sent;
  int results_checked;
  int updates_checked;
  int settings_used;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint clamp_s16(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic wheel_state_t wheel_tick(input wheel_state_t w);
    longint err;
    longint delta;
    longint g;
    longint s;
    err   = clamp_s16(longint'(cfg_target) - longint'(w.pulses));
    delta = err * longint'(cfg_prop) + longint'(w.last_err) * longint'(cfg_prev)
          + longint'(w.err_sum) * longint'(cfg_integ);
    g = longint'(w.gain) + delta;
    if (g >= GAIN_ONE) g = GAIN_ONE;
    else if (g <= 0) g = 0;
    s = clamp_s16(longint'(w.err_sum) + err);
    w.gain     = g[GAIN_W-1:0];
    w.pulses   = '0;
    w.last_err = err[ERR_W-1:0];
    w.err_sum  = s[ERR_W-1:0];
    return w;
  endfunction

  function automatic logic [DUTY_W-1:0] duty_of(input logic [BASE_W-1:0] base,
                                                input logic [GAIN_W-1:0] gain);
    longint p;
    p = longint'(base) * longint'(gain);
    return p[FRAC_BITS_DEF +: DUTY_W];
  endfunction

  // Count pulses, run the update on a tick, and give the duty item
  task automatic advance_wheels(input in_item_t it, output out_item_t res);
    if (it.left_pulse && longint'(left_w.pulses) < PULSE_MAX) left_w.pulses++;
    if (it.right_pulse && longint'(right_w.pulses) < PULSE_MAX) right_w.pulses++;
    if (it.tick) begin
      left_w  = wheel_tick(left_w);
      right_w = wheel_tick(right_w);
    end
    res.left_duty  = duty_of(cfg_left_base, left_w.gain);
    res.right_duty = duty_of(cfg_right_base, right_w.gain);
    res.updated    = it.tick;
  endtask

  function automatic in_item_t pulse_item(input logic l, input logic r, input logic t);
    in_item_t it;
    it.left_pulse  = l;
    it.right_pulse = r;
    it.tick        = t;
    return it;
  endfunction

  task automatic report_field(input string name, input int want, input int got);
    errors++;
    $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
  endtask

  // Drive the write on a rising edge, then drop the strobe and update the model copy
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_TARGET:     cfg_target     = val[TGT_W-1:0];
      CFG_LEFT_BASE:  cfg_left_base  = val;
      CFG_RIGHT_BASE: cfg_right_base = val;
      CFG_PROP:       cfg_prop       = val;
      CFG_INTEG:      cfg_integ      = val;
      CFG_PREV:       cfg_prev       = val;
      default: ;
    endcase
  endtask

  task automatic write_settings(input logic [CFG_DATA_W-1:0] tgt, input logic [15:0] lb,
                                input logic [15:0] rb, input logic [15:0] kp,
                                input logic [15:0] ki, input logic [15:0] kd);
    write_reg(CFG_TARGET, tgt);
    write_reg(CFG_LEFT_BASE, lb);
    write_reg(CFG_RIGHT_BASE, rb);
    write_reg(CFG_PROP, kp);
    write_reg(CFG_INTEG, ki);
    write_reg(CFG_PREV, kd);
    settings_used++;
    @(negedge clk);
  endtask

  task automatic write_random_setting();
    logic [7:0] tgt;
    tgt = ($urandom_range(0, 7) == 0) ? 8'd255 : 8'($urandom_range(0, 24));
    // upper bits of the target word carry noise and must be dropped
    write_settings({8'($urandom), tgt}, 16'($urandom), 16'($urandom),
                   16'($urandom_range(0, 6000)), 16'($urandom_range(0, 1500)),
                   16'($urandom_range(0, 3000)));
  endtask

  // Control periods: a run of pulse items closed by a tick, with some noise
  task automatic queue_periods(input int n_items);
    int queued;
    int span;
    queued = 0;
    while (queued < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        pending_items.push_back(in_item_t'(3'($urandom_range(0, 7))));
        queued++;
      end else begin
        span = $urandom_range(0, 2 * int'(cfg_target) + 2);
        if (span > 40) span = 40;
        for (int i = 0; i < span; i++)
          pending_items.push_back(pulse_item($urandom_range(0, 3) != 0,
                                             $urandom_range(0, 3) != 0, 1'b0));
        pending_items.push_back(pulse_item(1'($urandom_range(0, 1)),
                                           1'($urandom_range(0, 1)), 1'b1));
        queued += span + 1;
      end
    end
  endtask

  // Hold the sender until the block has returned every result
  task automatic wait_drained();
    @(negedge clk);
    while (pending_items.size() != 0 || duty_expect.size() != 0 || pulse_ch.valid)
      @(negedge clk);
  endtask

  always @(posedge clk) begin : drive_pulses
    out_item_t predicted;
    if (rst) begin
      pulse_ch.valid <= 1'b0;
      src_gap = 0;
    end else if (!pulse_ch.valid || pulse_ch.ready) begin
      if (pulse_ch.valid) begin
        advance_wheels(pulse_ch.data, predicted);
        duty_expect.push_back(predicted);
        items_sent++;
      end
      if (src_gap > 0) begin
        src_gap--;
        pulse_ch.valid <= 1'b0;
      end else if (pending_items.size() == 0) begin
        pulse_ch.valid <= 1'b0;
      end else if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
        src_gap = $urandom_range(0, 16);
        pulse_ch.valid <= 1'b0;
      end else begin
        pulse_ch.valid <= 1'b1;
        pulse_ch.data  <= pending_items.pop_front();
      end
    end
  end

  always @(posedge clk) begin : watch_duty
    out_item_t want;
    if (rst) begin
      duty_ch.ready <= 1'b0;
      snk_gap   = 0;
      hold_left = 0;
    end else begin
      if (duty_ch.valid && duty_ch.ready) begin
        if (duty_expect.size() == 0) begin
          errors++;
          $display("%0t: duty item with nothing expected: expected none, actual %0d/%0d/%0d",
                   $time, duty_ch.data.left_duty, duty_ch.data.right_duty,
                   duty_ch.data.updated);
        end else begin
          want = duty_expect.pop_front();
          if (duty_ch.data.left_duty !== want.left_duty)
            report_field("left_duty", want.left_duty, duty_ch.data.left_duty);
          if (duty_ch.data.right_duty !== want.right_duty)
            report_field("right_duty", want.right_duty, duty_ch.data.right_duty);
          if (duty_ch.data.updated !== want.updated)
            report_field("updated", want.updated, duty_ch.data.updated);
          results_checked++;
          if (want.updated) updates_checked++;
        end
      end
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        duty_ch.ready <= 1'b0;
      end else if (snk_gap > 0) begin
        snk_gap--;
        duty_ch.ready <= 1'b0;
      end else if (snk_idle_pct != 0 && $urandom_range(0, 99) < snk_idle_pct) begin
        snk_gap = $urandom_range(0, 16);
        duty_ch.ready <= 1'b0;
      end else begin
        duty_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (pulse_ch.valid && pulse_ch.ready) || (duty_ch.valid && duty_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin : stimulus
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    pulse_ch.valid = 1'b0;
    pulse_ch.data  = '0;
    duty_ch.ready  = 1'b0;
    src_idle_pct   = 20;
    snk_idle_pct   = 20;
    hold_requests  = 0;
    hold_served    = 0;
    errors         = 0;
    settings_used  = 1;
    cfg_target     = TARGET_RST;
    cfg_left_base  = BASE_RST;
    cfg_right_base = BASE_RST;
    cfg_prop       = PROP_RST;
    cfg_integ      = INTEG_RST;
    cfg_prev       = PREV_RST;
    left_w         = '{pulses: '0, last_err: '0, err_sum: '0, gain: GAIN_ONE[GAIN_W-1:0]};
    right_w        = left_w;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset values: idle item, bare tick, single pulses, periods on and off target
    pending_items.push_back(pulse_item(1'b0, 1'b0, 1'b0));
    pending_items.push_back(pulse_item(1'b0, 1'b0, 1'b1));
    pending_items.push_back(pulse_item(1'b1, 1'b0, 1'b0));
    pending_items.push_back(pulse_item(1'b0, 1'b1, 1'b0));
    pending_items.push_back(pulse_item(1'b1, 1'b1, 1'b0));
    pending_items.push_back(pulse_item(1'b1, 1'b1, 1'b1));
    pending_items.push_back(pulse_item(1'b1, 1'b0, 1'b1));
    pending_items.push_back(pulse_item(1'b0, 1'b1, 1'b1));
    repeat (12) pending_items.push_back(pulse_item(1'b1, 1'b1, 1'b0));
    pending_items.push_back(pulse_item(1'b1, 1'b1, 1'b1));
    queue_periods(60);
    wait_drained();

    // Upper extremes with a zero right base, plus writes to indexes that hold no register
    src_idle_pct = 30;
    snk_idle_pct = 0;
    write_settings(16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    write_reg(CFG_SPARE6, 16'hFFFF);
    write_reg(CFG_SPARE7, 16'h0000);
    @(negedge clk);
    queue_periods(40);
    wait_drained();

    // Lower extremes with a full right base: zero coefficients freeze the gains
    src_idle_pct = 0;
    snk_idle_pct = 30;
    write_settings(16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
    queue_periods(40);
    wait_drained();

    src_idle_pct = 15;
    snk_idle_pct = 15;
    for (int ph = 0; ph < 3; ph++) begin
      write_random_setting();
      queue_periods(40);
      // long hold-off on the duty side while items keep coming
      if (ph == 0) hold_requests++;
      wait_drained();
    end

    // Ticks with no pulses drive both error sums to the upper limit
    src_idle_pct = 10;
    snk_idle_pct = 10;
    write_settings(16'd255, 16'd40000, 16'd20000, 16'd100, 16'd50, 16'd100);
    repeat (140) pending_items.push_back(pulse_item(1'b0, 1'b0, 1'b1));
    wait_drained();
    // A small integral term shows whether the sum was held at its limit
    write_settings(16'd0, 16'd50000, 16'd30000, 16'd2000, 16'd1, 16'd0);
    repeat (20) pending_items.push_back(pulse_item(1'b1, 1'b1, 1'b0));
    pending_items.push_back(pulse_item(1'b0, 1'b0, 1'b1));
    queue_periods(30);
    wait_drained();

    // Long pulse runs against a zero target drive both errors negative
    src_idle_pct = 0;
    snk_idle_pct = 0;
    write_settings(16'd0, 16'd60000, 16'd12345, 16'd3, 16'd1, 16'd1);
    repeat (FILL_ITEMS) pending_items.push_back(pulse_item(1'b1, 1'b1, 1'b0));
    pending_items.push_back(pulse_item(1'b1, 1'b1, 1'b1));
    repeat (3) pending_items.push_back(pulse_item(1'b1, 1'b1, 1'b0));
    pending_items.push_back(pulse_item(1'b1, 1'b0, 1'b1));
    pending_items.push_back(pulse_item(1'b0, 1'b1, 1'b1));
    pending_items.push_back(pulse_item(1'b0, 1'b0, 1'b1));
    wait_drained();

    // Closing stretch with both sides always ready
    write_random_setting();
    queue_periods(50);
    wait_drained();

    repeat (TAIL_CYCLES) @(negedge clk);
    if (duty_expect.size() != 0)
      $display("%0t: duty items missing: expected %0d more, actual 0",
               $time, duty_expect.size());
    errors += duty_expect.size();
    $display("covered %0d items, %0d duty items checked, %0d of them control updates",
             items_sent, results_checked, updates_checked);
    $display("across %0d register settings, with the error sums held at their upper limit",
             settings_used);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/dwp_pkg.sv
src/dwp_if.sv
src/dwp_mac.sv
src/dual_wheel_pid_duty.sv
src/dwp_checker.sv
sim/testbench.sv
